// File: rtl/pwq_pkg.sv
// pwq_pkg: shared types and constants for the priority wait queue.
// Used by pwq_slot_ram, pwq_seq and priority_wait_queue; no dependencies.
package pwq_pkg;

   localparam int MAX_TASKS_DEF = 16;
   localparam int TASK_IDS      = 16;
   localparam int TID_W         = 4;
   localparam int PRIO_W        = 8;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   typedef struct packed {
      logic [TID_W-1:0]  tid;
      logic [PRIO_W-1:0] prio;
   } pwq_slot_type;

   typedef struct packed {
      logic              accepted;
      logic              front_valid;
      logic [TID_W-1:0]  front_task;
      logic [PRIO_W-1:0] front_priority;
   } pwq_result_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_INS_PUT,
      ST_REM_RD,
      ST_REM_CMP,
      ST_DONE
   } pwq_state_type;

endpackage

// File: rtl/pwq_slot_ram.sv
// pwq_slot_ram: ordered slot store, one write and one registered read per cycle.
// Depends on pwq_pkg for the slot type.
module pwq_slot_ram
   import pwq_pkg::*;
#(
   parameter int DEPTH = MAX_TASKS_DEF,
   parameter int AW    = $clog2(MAX_TASKS_DEF)
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  pwq_slot_type  wdata,
   input  logic [AW-1:0] raddr,
   output pwq_slot_type  rdata
);

   pwq_slot_type mem [DEPTH];
   pwq_slot_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/pwq_seq.sv
// pwq_seq: sequencer walking the slot RAM for insert and remove, with the
// queued flags, fill count and cached front entry. Depends on pwq_pkg, pwq_slot_ram.
module pwq_seq
   import pwq_pkg::*;
#(
   parameter int MAX_TASKS = MAX_TASKS_DEF,
   parameter int AW        = $clog2(MAX_TASKS_DEF),
   parameter int CW        = $clog2(MAX_TASKS_DEF + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_cmd,
   input  logic [TID_W-1:0] req_tid,
   input  logic [PRIO_W-1:0] req_prio,
   output logic             res_valid,
   input  logic             res_taken,
   output pwq_result_type   res,
   output logic [CW-1:0]    res_count
);

   pwq_state_type state_ff, state_in;
   logic [CW-1:0] k_ff, k_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic found_ff, found_in;
   logic ok_ff, ok_in;
   logic [TASK_IDS-1:0] queued_ff, queued_in;
   logic [TID_W-1:0] id_ff, id_in;
   logic [PRIO_W-1:0] pri_ff, pri_in;
   pwq_slot_type front_ff, front_in;

   logic [CW-1:0] km1, km2, kp1;
   logic          we;
   logic [AW-1:0] waddr, raddr;
   pwq_slot_type  wdata, rdata;

   pwq_slot_ram #(.DEPTH(MAX_TASKS), .AW(AW)) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   assign km1 = k_ff - CW'(1);
   assign km2 = k_ff - CW'(2);
   assign kp1 = k_ff + CW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         fill_ff   <= '0;
         queued_ff <= '0;
         ok_ff     <= 1'b0;
         found_ff  <= 1'b0;
         k_ff      <= '0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         queued_ff <= queued_in;
         ok_ff     <= ok_in;
         found_ff  <= found_in;
         k_ff      <= k_in;
      end
      id_ff    <= id_in;
      pri_ff   <= pri_in;
      front_ff <= front_in;
   end

   always_comb begin
      state_in  = state_ff;
      k_in      = k_ff;
      fill_in   = fill_ff;
      found_in  = found_ff;
      ok_in     = ok_ff;
      queued_in = queued_ff;
      id_in     = id_ff;
      pri_in    = pri_ff;
      we        = 1'b0;
      waddr     = k_ff[AW-1:0];
      wdata     = rdata;
      raddr     = '0;
      res_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               id_in  = req_tid;
               pri_in = req_prio;
               if (req_cmd == CMD_INSERT) begin
                  if (queued_ff[req_tid] || fill_ff == CW'(MAX_TASKS)) begin
                     ok_in    = 1'b0;
                     state_in = ST_DONE;
                  end else begin
                     k_in     = fill_ff;
                     state_in = (fill_ff == '0) ? ST_INS_PUT : ST_INS_RD;
                  end
               end else begin
                  if (!queued_ff[req_tid]) begin
                     ok_in    = 1'b0;
                     state_in = ST_DONE;
                  end else begin
                     k_in     = '0;
                     found_in = 1'b0;
                     state_in = ST_REM_RD;
                  end
               end
            end
         end
         ST_INS_RD: begin
            raddr    = km1[AW-1:0];
            state_in = ST_INS_CMP;
         end
         ST_INS_CMP: begin
            // walk from the tail, moving up every entry that sorts after us
            if (pri_ff < rdata.prio) begin
               we       = 1'b1;
               waddr    = k_ff[AW-1:0];
               wdata    = rdata;
               raddr    = km2[AW-1:0];
               k_in     = km1;
               state_in = (km1 == '0) ? ST_INS_PUT : ST_INS_CMP;
            end else begin
               state_in = ST_INS_PUT;
            end
         end
         ST_INS_PUT: begin
            we               = 1'b1;
            waddr            = k_ff[AW-1:0];
            wdata.tid        = id_ff;
            wdata.prio       = pri_ff;
            queued_in[id_ff] = 1'b1;
            fill_in          = fill_ff + CW'(1);
            ok_in            = 1'b1;
            state_in         = ST_DONE;
         end
         ST_REM_RD: begin
            raddr    = '0;
            state_in = ST_REM_CMP;
         end
         ST_REM_CMP: begin
            // next read issued now; once the match is seen, slide entries down
            raddr = kp1[AW-1:0];
            if (found_ff) begin
               we    = 1'b1;
               waddr = km1[AW-1:0];
               wdata = rdata;
            end else if (rdata.tid == id_ff) begin
               found_in = 1'b1;
            end
            k_in = kp1;
            if (kp1 == fill_ff) begin
               fill_in          = fill_ff - CW'(1);
               queued_in[id_ff] = 1'b0;
               ok_in            = 1'b1;
               state_in         = ST_DONE;
            end
         end
         ST_DONE: begin
            res_valid = 1'b1;
            if (res_taken) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // slot 0 is mirrored here so the front is always at hand
   assign front_in = (we && waddr == '0) ? wdata : front_ff;

   assign req_ready          = (state_ff == ST_IDLE);
   assign res.accepted       = ok_ff;
   assign res.front_valid    = (fill_ff != '0);
   assign res.front_task     = res.front_valid ? front_ff.tid : '0;
   assign res.front_priority = res.front_valid ? front_ff.prio : '0;
   assign res_count          = fill_ff;

`ifndef SYNTH
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(MAX_TASKS))
      else $error("fill count beyond depth");

   a_flags_match_fill: assert property (@(posedge clock) disable iff (reset)
      $countones(queued_ff) == int'(fill_ff))
      else $error("queued flags disagree with fill count");

   a_dup_insert_rejected: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid && req_cmd == CMD_INSERT && queued_ff[req_tid])
      |=> (state_ff == ST_DONE && !ok_ff && $stable(fill_ff)))
      else $error("duplicate insert not rejected");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !res_taken)
      |=> (state_ff == ST_DONE && $stable(fill_ff) && $stable(ok_ff)))
      else $error("pending result changed");
`endif

endmodule

// File: rtl/priority_wait_queue.sv
// Priority wait queue: stable priority-ordered list of task ids, one entry per task.
// Rejected ops go straight to the result; an insert walks from the tail, moving entries that
// sort after it toward the tail, then writes it; a remove walks every entry from the front.
// One word at a time: a new request is taken only once the last result has left the sequencer.
// Reset (synchronous): clears queued flags, count, sequencer and output valid;
// slot RAM contents are not cleared. Depends on pwq_pkg, pwq_seq, pwq_slot_ram.
module priority_wait_queue
   import pwq_pkg::*;
#(
   parameter int MAX_TASKS = MAX_TASKS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [15:0]      req_tdata,   // task_id[3:0], priority_req[11:4], zero pad
   input  logic             req_tuser,   // command
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // accepted, front_valid, front_task[4], front_priority[8], waiting_count, zero pad
   output logic [((14 + $clog2(MAX_TASKS + 1) + 7) / 8) * 8 - 1:0] rsp_tdata
);

   localparam int AW    = $clog2(MAX_TASKS);
   localparam int CW    = $clog2(MAX_TASKS + 1);
   localparam int RSP_W = ((14 + CW + 7) / 8) * 8;

   logic           res_valid;
   logic           res_taken;
   pwq_result_type res;
   logic [CW-1:0]  res_count;

   logic             rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   pwq_seq #(.MAX_TASKS(MAX_TASKS), .AW(AW), .CW(CW)) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_cmd   (req_tuser),
      .req_tid   (req_tdata[3:0]),
      .req_prio  (req_tdata[11:4]),
      .res_valid (res_valid),
      .res_taken (res_taken),
      .res       (res),
      .res_count (res_count)
   );

   assign res_taken     = res_valid && (!rsp_tvalid_ff || rsp_tready);
   assign rsp_tvalid_in = res_taken || (rsp_tvalid_ff && !rsp_tready);
   assign rsp_tdata_in  = res_taken
      ? RSP_W'({res_count, res.front_priority, res.front_task, res.front_valid, res.accepted})
      : rsp_tdata_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

// File: tb/priority_wait_queue_tb.sv
// Self-checking testbench for priority_wait_queue: a directed table of words, then random
// insert/remove traffic, each response checked against a priority-ordered list model or a typed report.
// Depends on pwq_pkg and the priority_wait_queue RTL.
`timescale 1ns / 100ps

module priority_wait_queue_tb
   import pwq_pkg::*;
();

   localparam int QUEUE_DEPTH   = MAX_TASKS_DEF;
   localparam int RSP_W         = ((14 + $clog2(QUEUE_DEPTH + 1) + 7) / 8) * 8;
   localparam int RESET_CYCLES  = 8;
   localparam int IDLE_PCT      = 19;
   localparam int NUM_DIRECTED  = 25;
   localparam int RANDOM_WORDS  = 650;
   localparam int HOLD_CYCLES   = 400;
   localparam int HOLD_AT_WORD  = 150;
   localparam int DRAIN_CYCLES  = 40;

   // packed so that bit 0 is accepted, matching the rsp_tdata layout
   typedef struct packed {
      logic [4:0]        waiting_count;
      logic [PRIO_W-1:0] front_priority;
      logic [TID_W-1:0]  front_task;
      logic              front_valid;
      logic              accepted;
   } queue_report_type;

   typedef struct packed {
      logic              cmd;
      logic [TID_W-1:0]  tid;
      logic [PRIO_W-1:0] prio;
      logic              typed;
      queue_report_type  report;
   } stim_row_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic [15:0]      req_tdata  = '0;   // task_id[3:0], priority_req[11:4], zero pad
   logic             req_tuser  = 1'b0; // command
   logic             rsp_tready = 1'b0;
   logic             req_tready;
   logic             rsp_tvalid;
   // accepted, front_valid, front_task[4], front_priority[8], waiting_count[5], zero pad
   logic [RSP_W-1:0] rsp_tdata;

   // priority-ordered list model, front at index 0
   logic [TID_W-1:0]  order_task [QUEUE_DEPTH];
   logic [PRIO_W-1:0] order_prio [QUEUE_DEPTH];
   bit                is_waiting [TASK_IDS];
   int                queue_fill = 0;

   queue_report_type expected_reports [$];
   int               mismatches = 0;
   bit               no_idle    = 1'b0;

   priority_wait_queue #(
      .MAX_TASKS (QUEUE_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

   function automatic queue_report_type apply_command(input logic cmd,
                                                      input logic [TID_W-1:0] tid,
                                                      input logic [PRIO_W-1:0] prio);
      queue_report_type r;
      int               pos;
      int               k;
      logic             done;
      done = 1'b0;
      if (cmd == CMD_INSERT) begin
         if (!is_waiting[tid] && queue_fill < QUEUE_DEPTH) begin
            // stable: goes ahead of the first strictly larger priority only
            pos = queue_fill;
            for (k = queue_fill - 1; k >= 0; k--)
               if (prio < order_prio[k]) pos = k;
            for (k = queue_fill; k > pos; k--) begin
               order_task[k] = order_task[k-1];
               order_prio[k] = order_prio[k-1];
            end
            order_task[pos] = tid;
            order_prio[pos] = prio;
            is_waiting[tid] = 1'b1;
            queue_fill++;
            done = 1'b1;
         end
      end else if (is_waiting[tid]) begin
         pos = queue_fill;
         for (k = queue_fill - 1; k >= 0; k--)
            if (order_task[k] == tid) pos = k;
         for (k = pos; k + 1 < queue_fill; k++) begin
            order_task[k] = order_task[k+1];
            order_prio[k] = order_prio[k+1];
         end
         queue_fill--;
         is_waiting[tid] = 1'b0;
         done = 1'b1;
      end
      r.accepted      = done;
      r.front_valid   = (queue_fill > 0);
      r.front_task    = (queue_fill > 0) ? order_task[0] : '0;
      r.front_priority = (queue_fill > 0) ? order_prio[0] : '0;
      r.waiting_count = queue_fill[4:0];
      return r;
   endfunction

   function automatic queue_report_type report(input logic acc, input logic fv,
                                               input logic [TID_W-1:0] ft,
                                               input logic [PRIO_W-1:0] fp,
                                               input logic [4:0] cnt);
      queue_report_type r;
      r.accepted       = acc;
      r.front_valid    = fv;
      r.front_task     = ft;
      r.front_priority = fp;
      r.waiting_count  = cnt;
      return r;
   endfunction

   function automatic stim_row_type stim_row(input logic cmd, input logic [TID_W-1:0] tid,
                                             input logic [PRIO_W-1:0] prio, input logic typed,
                                             input queue_report_type r);
      stim_row_type row;
      row.cmd    = cmd;
      row.tid    = tid;
      row.prio   = prio;
      row.typed  = typed;
      row.report = r;
      return row;
   endfunction

   // finds a task id that is (or is not) waiting, from a random start; random if none
   function automatic logic [TID_W-1:0] pick_task(input bit want_waiting);
      logic [TID_W-1:0] start;
      logic [TID_W-1:0] id;
      int               k;
      logic             found;
      start = TID_W'($urandom_range(0, TASK_IDS - 1));
      found = 1'b0;
      id    = start;
      for (k = 0; k < TASK_IDS; k++) begin
         if (!found && is_waiting[TID_W'(start + k)] == want_waiting) begin
            id    = TID_W'(start + k);
            found = 1'b1;
         end
      end
      return id;
   endfunction

   function void compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   task automatic offer_word(input logic cmd, input logic [TID_W-1:0] tid,
                             input logic [PRIO_W-1:0] prio, input logic typed,
                             input queue_report_type typed_report);
      queue_report_type predicted;
      if (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < IDLE_PCT) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {4'b0000, prio, tid};
      // ready only moves at the rising edge; seen high mid-cycle, the next edge takes the word
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      predicted = apply_command(cmd, tid, prio);
      expected_reports.push_back(typed ? typed_report : predicted);
   endtask

   // stimulus
   initial begin
      stim_row_type      directed_rows [NUM_DIRECTED];
      logic              cmd;
      logic [TID_W-1:0]  tid;
      logic [PRIO_W-1:0] prio;
      int                ins_pct;
      bit                filling;

      directed_rows[0]  = stim_row(CMD_REMOVE, 4'd5,  8'd0,   1'b1, report(0, 0, 0, 0, 0));
      directed_rows[1]  = stim_row(CMD_INSERT, 4'd0,  8'd255, 1'b1, report(1, 1, 0, 255, 1));
      directed_rows[2]  = stim_row(CMD_INSERT, 4'd15, 8'd0,   1'b1, report(1, 1, 15, 0, 2));
      directed_rows[3]  = stim_row(CMD_INSERT, 4'd15, 8'd170, 1'b1, report(0, 1, 15, 0, 2));
      directed_rows[4]  = stim_row(CMD_INSERT, 4'd3,  8'd0,   1'b0, '0);  // tie at front
      directed_rows[5]  = stim_row(CMD_REMOVE, 4'd15, 8'd255, 1'b0, '0);
      directed_rows[6]  = stim_row(CMD_REMOVE, 4'd15, 8'd0,   1'b1, report(0, 1, 3, 0, 2));
      directed_rows[7]  = stim_row(CMD_INSERT, 4'd15, 8'd85,  1'b0, '0);
      directed_rows[8]  = stim_row(CMD_INSERT, 4'd1,  8'd170, 1'b0, '0);
      directed_rows[9]  = stim_row(CMD_INSERT, 4'd2,  8'd85,  1'b0, '0);
      directed_rows[10] = stim_row(CMD_INSERT, 4'd4,  8'd255, 1'b0, '0);
      directed_rows[11] = stim_row(CMD_INSERT, 4'd5,  8'd0,   1'b0, '0);
      directed_rows[12] = stim_row(CMD_INSERT, 4'd6,  8'd170, 1'b0, '0);
      directed_rows[13] = stim_row(CMD_INSERT, 4'd7,  8'd85,  1'b0, '0);
      directed_rows[14] = stim_row(CMD_INSERT, 4'd8,  8'd1,   1'b0, '0);
      directed_rows[15] = stim_row(CMD_INSERT, 4'd9,  8'd254, 1'b0, '0);
      directed_rows[16] = stim_row(CMD_INSERT, 4'd10, 8'd128, 1'b0, '0);
      directed_rows[17] = stim_row(CMD_INSERT, 4'd11, 8'd127, 1'b0, '0);
      directed_rows[18] = stim_row(CMD_INSERT, 4'd12, 8'd85,  1'b0, '0);
      directed_rows[19] = stim_row(CMD_INSERT, 4'd13, 8'd2,   1'b0, '0);
      directed_rows[20] = stim_row(CMD_INSERT, 4'd14, 8'd200, 1'b0, '0);  // now full
      directed_rows[21] = stim_row(CMD_INSERT, 4'd7,  8'd9,   1'b0, '0);  // rejected, full
      directed_rows[22] = stim_row(CMD_REMOVE, 4'd0,  8'd0,   1'b0, '0);
      directed_rows[23] = stim_row(CMD_REMOVE, 4'd3,  8'd0,   1'b0, '0);  // front leaves
      directed_rows[24] = stim_row(CMD_INSERT, 4'd0,  8'd255, 1'b0, '0);  // lands at tail

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         offer_word(directed_rows[i].cmd, directed_rows[i].tid, directed_rows[i].prio,
                    directed_rows[i].typed, directed_rows[i].report);

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         no_idle <= (n >= 300 && n < 450);
         // alternate between phases that fill the queue and phases that drain it
         filling = ((n / 80) % 2) == 1;
         if ($urandom_range(0, 99) < 10) begin
            cmd = 1'($urandom_range(0, 1));
            tid = TID_W'($urandom_range(0, TASK_IDS - 1));
         end else begin
            ins_pct = filling ? 80 : 45;
            cmd = ($urandom_range(0, 99) < ins_pct) ? CMD_INSERT : CMD_REMOVE;
            tid = pick_task(cmd == CMD_REMOVE);
         end
         // narrow priorities half the time so ties are common
         if ($urandom_range(0, 1) == 1) prio = PRIO_W'($urandom_range(0, 7));
         else                           prio = PRIO_W'($urandom_range(0, 255));
         offer_word(cmd, tid, prio, 1'b0, '0);
      end
      req_tvalid <= 1'b0;

      while (expected_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // response side: checks each word, stalls at random, holds off once for a long stretch
   initial begin
      queue_report_type want;
      queue_report_type got;
      int               words_seen;
      int               hold_left;
      bit               hold_done;
      words_seen = 0;
      hold_left  = 0;
      hold_done  = 1'b0;
      forever begin
         // valid and ready only move at the rising edge; seen here, the next edge takes it
         @(negedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(queue_report_type)-1:0];
            words_seen++;
            if (expected_reports.size() == 0) begin
               $display("%0t: unexpected response word, expected none, actual %h",
                        $time, rsp_tdata);
               mismatches++;
            end else begin
               want = expected_reports.pop_front();
               compare_field("accepted", want.accepted, got.accepted);
               compare_field("front_valid", want.front_valid, got.front_valid);
               compare_field("front_task", want.front_task, got.front_task);
               compare_field("front_priority", want.front_priority, got.front_priority);
               compare_field("waiting_count", want.waiting_count, got.waiting_count);
            end
         end
         if (!hold_done && words_seen == HOLD_AT_WORD) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (no_idle) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

endmodule
